// ===== rtl/sfac_pkg.sv =====
`timescale 1ns / 1ps

package sfac_pkg;

    // Input commands. Codes five to seven carry no meaning and are dropped.
    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_WR_DIRECT   = 3'd1,
        CMD_WR_FAILSAFE = 3'd2,
        CMD_WR_DISARMED = 3'd3,
        CMD_WR_ARMING   = 3'd4
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_DROP_LIMIT  = 2'd0,
        CFG_TERM_ENABLE = 2'd1,
        CFG_SBUS1_EN    = 2'd2,
        CFG_SBUS2_EN    = 2'd3
    } cfg_idx_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_JUDGE = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    // Bit positions within the arming word.
    localparam int ARM_BIT      = 0;
    localparam int PREARM_BIT   = 1;
    localparam int LOCKDOWN_BIT = 2;
    localparam int FORCE_FS_BIT = 3;

    localparam logic [31:0] DROP_LIMIT_RESET = 32'd500000;

    // Decisions taken once per tick and held while the channels are emitted.
    typedef struct packed {
        logic link_ok;
        logic use_direct;
        logic failsafe;
        logic drive_sel;
        logic drive_dis;
    } tick_flags_t;

endpackage

// ===== rtl/servo_failsafe_arming_controller_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// s_        in         s_valid / s_ready       command, channel, pulse value, times, flags
// m_        out        m_valid / m_ready       one result beat per servo channel
// cfg_      in         cfg_valid / cfg_ready   register index, write data
//
// A table or arming write is taken and produces no beat. A tick passes through capture,
// judge and emit before the next item is taken: the item is captured in idle, then
// the single 32-bit subtract and compare judges the host link, and then the shared
// pulse selector produces one result beat per channel.
// The selector only advances when the output register is free, so a stalled m_ready
// stretches the tick for as long as a beat stalls. The last beat may still wait in the
// output register while the next item is accepted.
// Reset (aresetn low, synchronous) clears the tables, the arming word and all flags,
// and loads the drop limit with 500000 microseconds.

module servo_failsafe_arming_controller_top #(
    parameter int CHANNELS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [2:0]  s_channel,
    input  logic [15:0] s_pulse_value,
    input  logic [31:0] s_now_time,
    input  logic [31:0] s_host_rx_time,
    input  logic        s_init_ok,
    input  logic        s_safety_off,
    input  logic        s_raw_pwm,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_channel,
    output logic [15:0] m_pulse_width,
    output logic        m_drive,
    output logic        m_sbus1_send,
    output logic        m_sbus2_send,
    output logic        m_link_ok,
    output logic        m_link_initialized,
    output logic        m_failsafe_active,
    output logic        m_outputs_armed,
    output logic        m_last,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Counter width covers the channel count; a single channel still needs one bit.
    localparam int CNT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CHANNELS - 1);
    localparam logic [4:0] CHANNELS_EXT = 5'(CHANNELS);
    localparam logic [2:0] LAST_OUT_CH = 3'((CHANNELS - 1) % 8);

    // Configuration registers. Writes must arrive only while the block is idle; the block itself does not enforce this.
    logic [31:0] drop_limit_reg;
    logic        term_enable_reg;
    logic        sbus1_en_reg;
    logic        sbus2_en_reg;

    // Pulse tables, one entry per channel, read at the emit counter only.
    logic [15:0] direct_reg   [CHANNELS];
    logic [15:0] failsafe_reg [CHANNELS];
    logic [15:0] disarmed_reg [CHANNELS];

    logic [3:0]  arming_reg;
    logic        link_seen_reg;
    logic        armed_flag_reg;

    sfac_pkg::state_t state_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Tick fields captured on acceptance.
    logic [31:0] now_reg;
    logic [31:0] rx_reg;
    logic        init_ok_reg;
    logic        safety_off_reg;
    logic        raw_pwm_reg;

    sfac_pkg::tick_flags_t flags_reg;
    sfac_pkg::tick_flags_t flags_next;
    logic [3:0]  arming_next;
    logic        link_seen_next;
    logic        armed_flag_next;

    // Output register.
    logic        m_valid_reg;
    logic [2:0]  m_out_channel_reg;
    logic [15:0] m_pulse_width_reg;
    logic        m_drive_reg;
    logic        m_sbus1_reg;
    logic        m_sbus2_reg;
    logic        m_link_ok_reg;
    logic        m_link_init_reg;
    logic        m_failsafe_reg;
    logic        m_armed_reg;
    logic        m_last_reg;

    logic        s_accept;
    logic        cfg_accept;
    logic [4:0]  ch_ext;
    logic        ch_in_range;

    // Link judgement and tick decisions; evaluated in the judge cycle.
    logic [31:0] age;
    logic        link_ok_c;
    logic        arm_c;
    logic        arm_nothr_c;
    logic        always_c;
    logic        lockdown_c;
    logic        terminate_c;

    // Per-channel selector.
    logic        load_beat;
    logic [15:0] pw_c;
    logic        s1_c;
    logic        s2_c;
    logic [4:0]  cnt_ext;

    assign s_ready    = (state_reg == sfac_pkg::ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign ch_ext      = 5'(s_channel);
    assign ch_in_range = (ch_ext < CHANNELS_EXT);

    // A host receive time of zero means the host has never spoken. The age wraps
    // with the 32-bit clock, so an unsigned difference is the right measure.
    always_comb begin
        age            = now_reg - rx_reg;
        link_ok_c      = (rx_reg != 32'd0) && (age <= drop_limit_reg);
        link_seen_next = link_seen_reg || link_ok_c;

        arm_c       = init_ok_reg && safety_off_reg && arming_reg[sfac_pkg::ARM_BIT];
        arm_nothr_c = init_ok_reg && safety_off_reg &&
                      (arming_reg[sfac_pkg::PREARM_BIT] || raw_pwm_reg);
        always_c    = init_ok_reg && link_ok_c;

        flags_next.link_ok    = link_ok_c;
        flags_next.use_direct = raw_pwm_reg && link_ok_c;

        // Flight termination: when enabled, an armed vehicle that is not using direct pulses,
        // and whose host link has once been alive, latches forced failsafe.
        terminate_c = term_enable_reg && !flags_next.use_direct && arm_c && link_seen_next;
        arming_next = arming_reg;
        if (terminate_c) begin
            arming_next[sfac_pkg::FORCE_FS_BIT] = 1'b1;
        end

        flags_next.failsafe = arming_next[sfac_pkg::FORCE_FS_BIT];
        lockdown_c          = arming_next[sfac_pkg::LOCKDOWN_BIT];
        armed_flag_next     = arm_c || arm_nothr_c || always_c || lockdown_c;

        flags_next.drive_sel = armed_flag_next && !lockdown_c &&
                               (arm_c || arm_nothr_c || flags_next.failsafe);
        flags_next.drive_dis = !flags_next.drive_sel && armed_flag_next &&
                               (always_c || lockdown_c);
    end

    // Shared selector, used once per channel as the counter walks the tables.
    always_comb begin
        if (flags_reg.failsafe) begin
            pw_c = failsafe_reg[cnt_reg];
        end else if (flags_reg.use_direct) begin
            pw_c = direct_reg[cnt_reg];
        end else begin
            pw_c = disarmed_reg[cnt_reg];
        end
        s1_c = 1'b0;
        s2_c = 1'b0;
        if (flags_reg.drive_sel) begin
            s2_c = sbus2_en_reg;
            s1_c = sbus1_en_reg && !sbus2_en_reg;
        end else if (flags_reg.drive_dis) begin
            pw_c = disarmed_reg[cnt_reg];
            s1_c = sbus1_en_reg;
            s2_c = sbus2_en_reg;
        end
    end

    assign cnt_ext   = 5'(cnt_reg);
    assign load_beat = (state_reg == sfac_pkg::ST_EMIT) && (!m_valid_reg || m_ready);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drop_limit_reg  <= sfac_pkg::DROP_LIMIT_RESET;
            term_enable_reg <= 1'b0;
            sbus1_en_reg    <= 1'b0;
            sbus2_en_reg    <= 1'b0;
        end else if (cfg_accept) begin
            unique case (cfg_index)
                sfac_pkg::CFG_DROP_LIMIT:  drop_limit_reg  <= cfg_data;
                sfac_pkg::CFG_TERM_ENABLE: term_enable_reg <= cfg_data[0];
                sfac_pkg::CFG_SBUS1_EN:    sbus1_en_reg    <= cfg_data[0];
                sfac_pkg::CFG_SBUS2_EN:    sbus2_en_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer, tables and tick state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sfac_pkg::ST_IDLE;
            cnt_reg        <= '0;
            arming_reg     <= 4'd0;
            link_seen_reg  <= 1'b0;
            armed_flag_reg <= 1'b0;
            flags_reg      <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                direct_reg[i]   <= 16'd0;
                failsafe_reg[i] <= 16'd0;
                disarmed_reg[i] <= 16'd0;
            end
        end else begin
            unique case (state_reg)
                sfac_pkg::ST_IDLE: begin
                    if (s_accept) begin
                        case (s_command)
                            sfac_pkg::CMD_TICK: begin
                                state_reg <= sfac_pkg::ST_JUDGE;
                            end
                            sfac_pkg::CMD_WR_DIRECT: begin
                                if (ch_in_range) begin
                                    direct_reg[ch_ext[CNT_W-1:0]] <= s_pulse_value;
                                end
                            end
                            sfac_pkg::CMD_WR_FAILSAFE: begin
                                if (ch_in_range) begin
                                    failsafe_reg[ch_ext[CNT_W-1:0]] <= s_pulse_value;
                                end
                            end
                            sfac_pkg::CMD_WR_DISARMED: begin
                                if (ch_in_range) begin
                                    disarmed_reg[ch_ext[CNT_W-1:0]] <= s_pulse_value;
                                end
                            end
                            sfac_pkg::CMD_WR_ARMING: begin
                                arming_reg <= s_pulse_value[3:0];
                            end
                            default: ;
                        endcase
                    end
                end
                sfac_pkg::ST_JUDGE: begin
                    flags_reg      <= flags_next;
                    arming_reg     <= arming_next;
                    link_seen_reg  <= link_seen_next;
                    armed_flag_reg <= armed_flag_next;
                    cnt_reg        <= '0;
                    state_reg      <= sfac_pkg::ST_EMIT;
                end
                sfac_pkg::ST_EMIT: begin
                    if (load_beat) begin
                        if (cnt_reg == LAST_CNT) begin
                            state_reg <= sfac_pkg::ST_IDLE;
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= sfac_pkg::ST_IDLE;
            endcase
        end
    end

    // Tick fields need no reset; they are always written before use.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            now_reg        <= s_now_time;
            rx_reg         <= s_host_rx_time;
            init_ok_reg    <= s_init_ok;
            safety_off_reg <= s_safety_off;
            raw_pwm_reg    <= s_raw_pwm;
        end
    end

    // Output register: valid is control state, the payload is not reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_beat) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_beat) begin
            m_out_channel_reg <= cnt_ext[2:0];
            m_pulse_width_reg <= pw_c;
            m_drive_reg       <= flags_reg.drive_sel || flags_reg.drive_dis;
            m_sbus1_reg       <= s1_c;
            m_sbus2_reg       <= s2_c;
            m_link_ok_reg     <= flags_reg.link_ok;
            m_link_init_reg   <= link_seen_reg;
            m_failsafe_reg    <= flags_reg.failsafe;
            m_armed_reg       <= armed_flag_reg;
            m_last_reg        <= (cnt_reg == LAST_CNT);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_out_channel      = m_out_channel_reg;
    assign m_pulse_width      = m_pulse_width_reg;
    assign m_drive            = m_drive_reg;
    assign m_sbus1_send       = m_sbus1_reg;
    assign m_sbus2_send       = m_sbus2_reg;
    assign m_link_ok          = m_link_ok_reg;
    assign m_link_initialized = m_link_init_reg;
    assign m_failsafe_active  = m_failsafe_reg;
    assign m_outputs_armed    = m_armed_reg;
    assign m_last             = m_last_reg;

    // The link judgement always hands over to the emit sequence.
    a_judge_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sfac_pkg::ST_JUDGE) |=> (state_reg == sfac_pkg::ST_EMIT))
        else $error("judge cycle not followed by emit");

    // The final beat of a tick belongs to the highest channel.
    a_last_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_out_channel == LAST_OUT_CH))
        else $error("last beat carries the wrong channel");

    // A servo is only ever driven while the outputs are armed.
    a_drive_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_drive) |-> m_outputs_armed)
        else $error("drive asserted with outputs disarmed");

    // A fresh link always counts as an initialised link.
    a_link_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_link_ok) |-> m_link_initialized)
        else $error("link ok without link initialised");

endmodule
